FILE: rtl/core/event_profiling_counters_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event profiling counters unit
// Implication checks on the rising clock edge, held off while reset is low.
// Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef EVENT_PROFILING_COUNTERS_UNIT_ASSERT_SVH
`define EVENT_PROFILING_COUNTERS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/epc_pkg.sv
// ----------------------------------------------------------------------------
// Event profiling counters package
// Field widths, request and status codes, counter entry layout and the
// sequencer states.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int NUM_EVENTS_DEF = 64;
    localparam int NEST_DEPTH_DEF = 8;

    localparam int REQ_W = 3;
    localparam int IDX_W = 6;
    localparam int CNT_W = 32;
    localparam int ST_W  = 2;

    // request codes; the remaining codes are no-ops
    localparam logic [REQ_W-1:0] REQ_ENTER  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LEAVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FSTART = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FEND   = 3'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_BACKWARDS = 2'd3;

    // per-frame minimum before any frame has been recorded
    localparam logic [CNT_W-1:0] MIN_NONE = 32'd9999999;

    typedef struct packed {
        logic [CNT_W-1:0] calls;
        logic [CNT_W-1:0] frames_hit;
        logic [CNT_W-1:0] total_ms;
        logic [CNT_W-1:0] frame_ms;
        logic [CNT_W-1:0] min_ms;
        logic [CNT_W-1:0] max_ms;
        logic             called;
    } ent_t;

    localparam ent_t ENT_RESET = '{
        calls:      '0,
        frames_hit: '0,
        total_ms:   '0,
        frame_ms:   '0,
        min_ms:     MIN_NONE,
        max_ms:     '0,
        called:     1'b0
    };

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_ARITH,
        S_WRITE,
        S_RESULT,
        S_SW_RD,
        S_SW_LOAD,
        S_SW_CMP,
        S_SW_WR,
        S_FCOUNT,
        S_FETCH
    } state_t;

endpackage

FILE: rtl/core/event_profiling_counters_unit.sv
// ----------------------------------------------------------------------------
// Event profiling counters unit
// Enter: look, two arithmetic steps, write, result. Leave: look, three
//   arithmetic steps, write, result, or from the first step straight to the
//   result when its timestamp went backwards. Query, refused, disabled or
//   spare items: look, result. A held result delays the load; the next item
//   is taken the cycle after the result loads. Frame start and frame end
//   sweep the table one entry at a time through one port, then fetch the entry.
// After reset a clearing pass over the table holds req_stall high.
`include "event_profiling_counters_unit_assert.svh"

module event_profiling_counters_unit #(
    parameter int NUM_EVENTS = epc_pkg::NUM_EVENTS_DEF,
    parameter int NEST_DEPTH = epc_pkg::NEST_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // enable register
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,

    // request channel
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [epc_pkg::REQ_W-1:0]   req_type,
    input  logic [epc_pkg::IDX_W-1:0]   event_index,
    input  logic [epc_pkg::CNT_W-1:0]   timestamp,

    // response channel
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [epc_pkg::ST_W-1:0]    status,
    output logic [epc_pkg::CNT_W-1:0]   call_total,
    output logic [epc_pkg::CNT_W-1:0]   frames_called,
    output logic [epc_pkg::CNT_W-1:0]   time_total,
    output logic [epc_pkg::CNT_W-1:0]   time_this_frame,
    output logic [epc_pkg::CNT_W-1:0]   min_per_frame,
    output logic [epc_pkg::CNT_W-1:0]   max_per_frame,
    output logic [epc_pkg::CNT_W-1:0]   frame_count
);

    // Counter memory address, stack slot select, level width (holds the
    // depth itself) and the start-time stack address.
    localparam int AW        = $clog2(NUM_EVENTS);
    localparam int LW        = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int LVW       = $clog2(NEST_DEPTH + 1);
    localparam int SAW       = AW + LW;
    localparam int STK_DEPTH = NUM_EVENTS * (2 ** LW);
    localparam int CW        = epc_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    epc_pkg::state_t                state_reg, state_next;
    logic                           en_reg, en_next;
    logic [epc_pkg::REQ_W-1:0]      req_reg, req_next;
    logic [epc_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                           idx_ok_reg, idx_ok_next;
    logic [CW-1:0]                  ts_reg, ts_next;
    logic [epc_pkg::ST_W-1:0]       st_reg, st_next;
    epc_pkg::ent_t                  work_reg, work_next;
    logic [LVW-1:0]                 lvl_reg, lvl_next;
    logic [CW-1:0]                  diff_reg, diff_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [1:0]                     step_reg, step_next;
    logic [CW-1:0]                  frames_done_reg, frames_done_next;

    // response register
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [epc_pkg::ST_W-1:0]       rsp_status_reg, rsp_status_next;
    logic [CW-1:0]                  rsp_calls_reg, rsp_calls_next;
    logic [CW-1:0]                  rsp_frames_reg, rsp_frames_next;
    logic [CW-1:0]                  rsp_total_reg, rsp_total_next;
    logic [CW-1:0]                  rsp_frame_ms_reg, rsp_frame_ms_next;
    logic [CW-1:0]                  rsp_min_reg, rsp_min_next;
    logic [CW-1:0]                  rsp_max_reg, rsp_max_next;
    logic [CW-1:0]                  rsp_fcount_reg, rsp_fcount_next;

    // ------------------------------------------------------------------
    // Memories: counter entries, nesting levels, start-time stacks
    // ------------------------------------------------------------------
    epc_pkg::ent_t                  ent_mem [NUM_EVENTS];
    logic [LVW-1:0]                 lvl_mem [NUM_EVENTS];
    logic [CW-1:0]                  stk_mem [STK_DEPTH];

    logic                           ent_rd_en;
    logic [AW-1:0]                  ent_rd_addr;
    epc_pkg::ent_t                  ent_q_reg;
    logic [LVW-1:0]                 lvl_q_reg;
    logic                           ent_we;
    logic [AW-1:0]                  ent_wr_addr;
    epc_pkg::ent_t                  ent_wdata;
    logic                           lvl_we;
    logic [LVW-1:0]                 lvl_wdata;

    logic                           stk_rd_en;
    logic [SAW-1:0]                 stk_rd_addr;
    logic [CW-1:0]                  stk_q_reg;
    logic                           stk_we;
    logic [SAW-1:0]                 stk_wr_addr;
    logic [CW-1:0]                  stk_wdata;

    // shared add / subtract unit
    logic [CW-1:0]                  alu_a, alu_b;
    logic                           alu_sub;
    logic [CW:0]                    alu_sum;
    logic [CW-1:0]                  alu_res;
    logic                           alu_borrow;

    // helpers
    logic                           req_accept;
    logic                           idx_ok_in;
    logic                           sweep_in;
    logic [AW-1:0]                  idx_addr;
    logic                           rmw_active;
    logic                           lvl_full;
    logic                           lvl_empty;
    logic                           look_refused;
    logic [LVW-1:0]                 lvl_dec;
    logic                           sweep_last;
    logic                           rsp_free;
    logic                           rsp_load;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign req_stall  = (state_reg != epc_pkg::S_IDLE);
    assign req_accept = req_valid && !req_stall;

    // indexes beyond the table touch nothing and answer reset values
    assign idx_ok_in  = (32'(event_index) < 32'(NUM_EVENTS));
    assign sweep_in   = en_reg && ((req_type == epc_pkg::REQ_FSTART) ||
                                   (req_type == epc_pkg::REQ_FEND));
    assign idx_addr   = AW'(idx_reg);

    assign rmw_active = en_reg && idx_ok_reg &&
                        ((req_reg == epc_pkg::REQ_ENTER) || (req_reg == epc_pkg::REQ_LEAVE));
    assign lvl_full   = (lvl_q_reg >= LVW'(NEST_DEPTH));
    assign lvl_empty  = (lvl_q_reg == '0);
    assign lvl_dec    = lvl_q_reg - LVW'(1);
    assign look_refused = ((req_reg == epc_pkg::REQ_ENTER) && lvl_full) ||
                          ((req_reg == epc_pkg::REQ_LEAVE) && lvl_empty);

    assign sweep_last = (addr_reg == AW'(NUM_EVENTS - 1));
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_load   = (state_reg == epc_pkg::S_RESULT) && rsp_free;

    // Shared unit: one 32-bit add or subtract per cycle, borrow out on top
    assign alu_sum    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_res    = alu_sum[CW-1:0];
    assign alu_borrow = alu_sum[CW];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            epc_pkg::S_CLEAR:
            begin
                // reset pass over the counter table
                if (sweep_last)
                    state_next = epc_pkg::S_IDLE;
            end
            epc_pkg::S_IDLE:
            begin
                if (req_accept)
                    state_next = sweep_in ? epc_pkg::S_SW_RD : epc_pkg::S_LOOK;
            end
            epc_pkg::S_LOOK:
            begin
                // a full stack on enter or an empty one on leave goes straight out
                if (rmw_active && !look_refused)
                    state_next = epc_pkg::S_ARITH;
                else
                    state_next = epc_pkg::S_RESULT;
            end
            epc_pkg::S_ARITH:
            begin
                if (req_reg == epc_pkg::REQ_ENTER)
                begin
                    if (step_reg == 2'd1)
                        state_next = epc_pkg::S_WRITE;
                end
                else
                begin
                    // leave: abandon on a timestamp that went backwards
                    if ((step_reg == 2'd0) && alu_borrow)
                        state_next = epc_pkg::S_RESULT;
                    else if (step_reg == 2'd2)
                        state_next = epc_pkg::S_WRITE;
                end
            end
            epc_pkg::S_WRITE:
            begin
                state_next = epc_pkg::S_RESULT;
            end
            epc_pkg::S_RESULT:
            begin
                if (rsp_free)
                    state_next = epc_pkg::S_IDLE;
            end
            epc_pkg::S_SW_RD:
            begin
                state_next = epc_pkg::S_SW_LOAD;
            end
            epc_pkg::S_SW_LOAD:
            begin
                if (req_reg == epc_pkg::REQ_FSTART)
                    state_next = epc_pkg::S_SW_WR;
                else if (ent_q_reg.called)
                    state_next = epc_pkg::S_SW_CMP;
                else if (sweep_last)
                    state_next = epc_pkg::S_FCOUNT;
                else
                    state_next = epc_pkg::S_SW_RD;
            end
            epc_pkg::S_SW_CMP:
            begin
                if (step_reg == 2'd1)
                    state_next = epc_pkg::S_SW_WR;
            end
            epc_pkg::S_SW_WR:
            begin
                if (!sweep_last)
                    state_next = epc_pkg::S_SW_RD;
                else if (req_reg == epc_pkg::REQ_FEND)
                    state_next = epc_pkg::S_FCOUNT;
                else
                    state_next = epc_pkg::S_FETCH;
            end
            epc_pkg::S_FCOUNT:
            begin
                state_next = epc_pkg::S_FETCH;
            end
            epc_pkg::S_FETCH:
            begin
                state_next = epc_pkg::S_LOOK;
            end
            default:
            begin
                state_next = epc_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs and datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        // hold by default
        en_next          = cfg_we ? cfg_wdata : en_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        idx_ok_next      = idx_ok_reg;
        ts_next          = ts_reg;
        st_next          = st_reg;
        work_next        = work_reg;
        lvl_next         = lvl_reg;
        diff_next        = diff_reg;
        addr_next        = addr_reg;
        step_next        = step_reg;
        frames_done_next = frames_done_reg;

        ent_rd_en   = 1'b0;
        ent_rd_addr = idx_addr;
        ent_we      = 1'b0;
        ent_wr_addr = idx_addr;
        ent_wdata   = work_reg;
        lvl_we      = 1'b0;
        lvl_wdata   = lvl_reg;
        stk_rd_en   = 1'b0;
        stk_rd_addr = {idx_addr, lvl_dec[LW-1:0]};
        stk_we      = 1'b0;
        stk_wr_addr = {idx_addr, lvl_reg[LW-1:0]};
        stk_wdata   = ts_reg;

        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;

        unique case (state_reg)
            epc_pkg::S_CLEAR:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = addr_reg;
                ent_wdata   = epc_pkg::ENT_RESET;
                lvl_we      = 1'b1;
                lvl_wdata   = '0;
                addr_next   = sweep_last ? '0 : addr_reg + AW'(1);
            end
            epc_pkg::S_IDLE:
            begin
                if (req_accept)
                begin
                    req_next    = req_type;
                    idx_next    = event_index;
                    idx_ok_next = idx_ok_in;
                    ts_next     = timestamp;
                    st_next     = epc_pkg::ST_OK;
                    addr_next   = '0;
                    ent_rd_en   = !sweep_in && idx_ok_in;
                    ent_rd_addr = AW'(event_index);
                end
            end
            epc_pkg::S_LOOK:
            begin
                work_next = ent_q_reg;
                lvl_next  = lvl_q_reg;
                step_next = 2'd0;
                if (rmw_active)
                begin
                    if ((req_reg == epc_pkg::REQ_ENTER) && lvl_full)
                        st_next = epc_pkg::ST_FULL;
                    if ((req_reg == epc_pkg::REQ_LEAVE) && lvl_empty)
                        st_next = epc_pkg::ST_EMPTY;
                    // fetch the start time on top of the stack
                    stk_rd_en = (req_reg == epc_pkg::REQ_LEAVE) && !lvl_empty;
                end
            end
            epc_pkg::S_ARITH:
            begin
                step_next = step_reg + 2'd1;
                if (req_reg == epc_pkg::REQ_ENTER)
                begin
                    if (step_reg == 2'd0)
                    begin
                        // count the call and push the start time
                        alu_a           = work_reg.calls;
                        alu_b           = CW'(1);
                        work_next.calls = alu_res;
                        stk_we          = 1'b1;
                    end
                    else
                    begin
                        // first call in this frame counts the frame
                        alu_a = work_reg.frames_hit;
                        alu_b = CW'(1);
                        if (!work_reg.called)
                        begin
                            work_next.frames_hit = alu_res;
                            work_next.called     = 1'b1;
                        end
                        lvl_next = lvl_reg + LVW'(1);
                    end
                end
                else
                begin
                    if (step_reg == 2'd0)
                    begin
                        alu_a   = ts_reg;
                        alu_b   = stk_q_reg;
                        alu_sub = 1'b1;
                        if (alu_borrow)
                            st_next = epc_pkg::ST_BACKWARDS;
                        else
                            diff_next = alu_res;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        alu_a              = work_reg.total_ms;
                        alu_b              = diff_reg;
                        work_next.total_ms = alu_res;
                    end
                    else
                    begin
                        alu_a              = work_reg.frame_ms;
                        alu_b              = diff_reg;
                        work_next.frame_ms = alu_res;
                        lvl_next           = lvl_reg - LVW'(1);
                    end
                end
            end
            epc_pkg::S_WRITE:
            begin
                ent_we = 1'b1;
                lvl_we = 1'b1;
            end
            epc_pkg::S_RESULT:
            begin
                // response load handled below
            end
            epc_pkg::S_SW_RD:
            begin
                ent_rd_en   = 1'b1;
                ent_rd_addr = addr_reg;
            end
            epc_pkg::S_SW_LOAD:
            begin
                work_next = ent_q_reg;
                step_next = 2'd0;
                if (req_reg == epc_pkg::REQ_FSTART)
                begin
                    work_next.called   = 1'b0;
                    work_next.frame_ms = '0;
                end
                else if (!ent_q_reg.called)
                begin
                    // not called this frame: skip the write-back
                    addr_next = sweep_last ? '0 : addr_reg + AW'(1);
                end
            end
            epc_pkg::S_SW_CMP:
            begin
                step_next = step_reg + 2'd1;
                alu_sub   = 1'b1;
                if (step_reg == 2'd0)
                begin
                    alu_a = work_reg.max_ms;
                    alu_b = work_reg.frame_ms;
                    if (alu_borrow)
                        work_next.max_ms = work_reg.frame_ms;
                end
                else
                begin
                    alu_a = work_reg.frame_ms;
                    alu_b = work_reg.min_ms;
                    if (alu_borrow)
                        work_next.min_ms = work_reg.frame_ms;
                end
            end
            epc_pkg::S_SW_WR:
            begin
                ent_we      = 1'b1;
                ent_wr_addr = addr_reg;
                addr_next   = sweep_last ? '0 : addr_reg + AW'(1);
            end
            epc_pkg::S_FCOUNT:
            begin
                alu_a            = frames_done_reg;
                alu_b            = CW'(1);
                frames_done_next = alu_res;
            end
            epc_pkg::S_FETCH:
            begin
                ent_rd_en = idx_ok_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Response register: loads once per item, drops when taken
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_status_next   = rsp_status_reg;
        rsp_calls_next    = rsp_calls_reg;
        rsp_frames_next   = rsp_frames_reg;
        rsp_total_next    = rsp_total_reg;
        rsp_frame_ms_next = rsp_frame_ms_reg;
        rsp_min_next      = rsp_min_reg;
        rsp_max_next      = rsp_max_reg;
        rsp_fcount_next   = rsp_fcount_reg;
        if (rsp_load)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = st_reg;
            rsp_fcount_next = frames_done_reg;
            if (idx_ok_reg)
            begin
                rsp_calls_next    = work_reg.calls;
                rsp_frames_next   = work_reg.frames_hit;
                rsp_total_next    = work_reg.total_ms;
                rsp_frame_ms_next = work_reg.frame_ms;
                rsp_min_next      = work_reg.min_ms;
                rsp_max_next      = work_reg.max_ms;
            end
            else
            begin
                rsp_calls_next    = '0;
                rsp_frames_next   = '0;
                rsp_total_next    = '0;
                rsp_frame_ms_next = '0;
                rsp_min_next      = epc_pkg::MIN_NONE;
                rsp_max_next      = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= epc_pkg::S_CLEAR;
            en_reg          <= 1'b1;
            addr_reg        <= '0;
            step_reg        <= '0;
            frames_done_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            en_reg          <= en_next;
            addr_reg        <= addr_next;
            step_reg        <= step_next;
            frames_done_reg <= frames_done_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        idx_reg          <= idx_next;
        idx_ok_reg       <= idx_ok_next;
        ts_reg           <= ts_next;
        st_reg           <= st_next;
        work_reg         <= work_next;
        lvl_reg          <= lvl_next;
        diff_reg         <= diff_next;
        rsp_status_reg   <= rsp_status_next;
        rsp_calls_reg    <= rsp_calls_next;
        rsp_frames_reg   <= rsp_frames_next;
        rsp_total_reg    <= rsp_total_next;
        rsp_frame_ms_reg <= rsp_frame_ms_next;
        rsp_min_reg      <= rsp_min_next;
        rsp_max_reg      <= rsp_max_next;
        rsp_fcount_reg   <= rsp_fcount_next;
    end

    // ------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wr_addr] <= ent_wdata;
        if (ent_rd_en)
            ent_q_reg <= ent_mem[ent_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
            lvl_mem[ent_wr_addr] <= lvl_wdata;
        if (ent_rd_en)
            lvl_q_reg <= lvl_mem[ent_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wr_addr] <= stk_wdata;
        if (stk_rd_en)
            stk_q_reg <= stk_mem[stk_rd_addr];
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign rsp_valid       = rsp_valid_reg;
    assign status          = rsp_status_reg;
    assign call_total      = rsp_calls_reg;
    assign frames_called   = rsp_frames_reg;
    assign time_total      = rsp_total_reg;
    assign time_this_frame = rsp_frame_ms_reg;
    assign min_per_frame   = rsp_min_reg;
    assign max_per_frame   = rsp_max_reg;
    assign frame_count     = rsp_fcount_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_lvl_bound, clk, rst_n, lvl_we, lvl_wdata <= LVW'(NEST_DEPTH), "nesting level written beyond depth")
    `ASSERT_IMPLY(a_push_room, clk, rst_n, stk_we, lvl_reg < LVW'(NEST_DEPTH), "start time pushed on a full stack")
    `ASSERT_NEXT(a_fcount_hold, clk, rst_n, state_reg != epc_pkg::S_FCOUNT, $stable(frames_done_reg), "frame count moved outside its step")

endmodule
